>>> hdl/rpp_pkg.sv
// ----------------------------------------------------------------------------
// RIP packet parser package
// Result layout, status codes, protocol constants and byte helpers.
// ----------------------------------------------------------------------------
package rpp_pkg;

    // Result kinds
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Packet status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_LENGTH    = 3'd1;
    localparam logic [2:0] ST_HEADER    = 3'd2;
    localparam logic [2:0] ST_FAMILY    = 3'd3;
    localparam logic [2:0] ST_METRIC    = 3'd4;
    localparam logic [2:0] ST_MASK      = 3'd5;
    localparam logic [2:0] ST_OVERFLOW  = 3'd6;
    localparam logic [2:0] ST_TRUNCATED = 3'd7;

    // RIP header values
    localparam logic [7:0]  CMD_REQUEST  = 8'h01;
    localparam logic [7:0]  CMD_RESPONSE = 8'h02;
    localparam logic [7:0]  RIP_VERSION  = 8'h02;
    localparam logic [15:0] FAMILY_INET  = 16'h0002;
    localparam logic [15:0] FAMILY_NONE  = 16'h0000;
    localparam logic [31:0] METRIC_MAX   = 32'd16;

    // Byte offsets in the packet
    localparam logic [15:0] OFS_IHL      = 16'd0;
    localparam logic [15:0] OFS_LEN_HI   = 16'd2;
    localparam logic [15:0] OFS_LEN_LO   = 16'd3;
    localparam logic [15:0] OFS_COMMAND  = 16'd28;
    localparam logic [15:0] OFS_VERSION  = 16'd29;
    localparam logic [15:0] OFS_ZERO0    = 16'd30;
    localparam logic [15:0] OFS_ZERO1    = 16'd31;
    localparam logic [15:0] OFS_ENTRIES  = 16'd32;
    localparam logic [15:0] INDEX_MAX    = 16'hFFFF;

    // Offsets inside one 20-byte route entry
    localparam logic [4:0] EO_FAM_LAST  = 5'd1;
    localparam logic [4:0] EO_ADDR      = 5'd4;
    localparam logic [4:0] EO_MASK      = 5'd8;
    localparam logic [4:0] EO_NEXTHOP   = 5'd12;
    localparam logic [4:0] EO_METRIC    = 5'd16;
    localparam logic [4:0] EO_LAST      = 5'd19;

    // x/20 == (x * 52429) >> 20, exact for any 16-bit x
    localparam logic [15:0] RECIP_20    = 16'd52429;
    localparam int          RECIP_SHIFT = 20;

    // Result queue depth
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic        kind;
        logic [31:0] route_addr;
        logic [31:0] route_mask;
        logic [31:0] route_nexthop;
        logic [31:0] route_metric;
        logic [2:0]  status;
        logic [7:0]  command;
        logic [4:0]  entry_count;
        logic        run_last;
    } t_result;

    // Results produced by one accepted byte, entry first
    typedef struct packed {
        logic    entry_valid;
        logic    summary_valid;
        t_result entry;
        t_result summary;
    } t_push;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

>>> hdl/rpp_if.sv
// ----------------------------------------------------------------------------
// RIP packet parser channels
// Valid/ready channels for packet bytes and parse results.
// ----------------------------------------------------------------------------
interface rpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rpp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] route_addr;
    logic [31:0] route_mask;
    logic [31:0] route_nexthop;
    logic [31:0] route_metric;
    logic [2:0]  status;
    logic [7:0]  command;
    logic [4:0]  entry_count;
    logic        run_last;

    modport source (output valid, output kind, output route_addr, output route_mask,
                    output route_nexthop, output route_metric, output status,
                    output command, output entry_count, output run_last, input ready);
    modport sink   (input valid, input kind, input route_addr, input route_mask,
                    input route_nexthop, input route_metric, input status,
                    input command, input entry_count, input run_last, output ready);
endinterface

>>> hdl/rpp_byte_parser.sv
// ----------------------------------------------------------------------------
// RIP packet parser byte stage
// Per-byte header tracking, entry assembly and checks; emits up to two results.
// ----------------------------------------------------------------------------
module rpp_byte_parser
    import rpp_pkg::*;
#(
    parameter int MAX_ENTRIES = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output t_push       o_push
);

    logic [15:0] r_byte_index, n_byte_index;
    logic [15:0] r_total_length, n_total_length;
    logic [3:0]  r_header_words, n_header_words;
    logic [7:0]  r_command, n_command;
    logic [11:0] r_expected, n_expected;
    logic [4:0]  r_emitted, n_emitted;
    logic [2:0]  r_error, n_error;
    logic [15:0] r_family, n_family;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_mask, n_mask;
    logic [31:0] r_nexthop, n_nexthop;
    logic [31:0] r_metric, n_metric;
    // position inside the entry area: byte within entry and entry number
    logic [4:0]  r_ent_off, n_ent_off;
    logic [11:0] r_ent_num, n_ent_num;

    logic [15:0] new_total;
    logic [6:0]  hdr_bytes;
    logic [15:0] body_bytes;
    logic [31:0] recip_prod;
    logic [31:0] metric_be;
    logic [31:0] mask_inv;
    logic        fam_ok;
    logic [16:0] byte_count;
    logic [2:0]  end_status;
    logic        entry_fire;
    logic [7:0]  cmd_now;

    // Expected entry count from total length and IHL
    assign new_total  = {r_total_length[15:8], i_data_byte};
    assign hdr_bytes  = {1'b0, r_header_words, 2'b00} + 7'd4;
    assign body_bytes = (new_total > {9'd0, hdr_bytes}) ? new_total - {9'd0, hdr_bytes}
                                                        : 16'd0;
    assign recip_prod = {16'd0, body_bytes} * {16'd0, RECIP_20};

    // Entry checks on the completed entry (metric includes this byte)
    assign metric_be = swap32({i_data_byte, r_metric[31:8]});
    assign mask_inv  = ~swap32(r_mask);
    assign fam_ok    = (r_command == CMD_RESPONSE && r_family == FAMILY_INET) ||
                       (r_command == CMD_REQUEST  && r_family == FAMILY_NONE);
    assign byte_count = {1'b0, r_byte_index} + 17'd1;

    // Command as seen after this byte, for a summary on the command byte itself
    assign cmd_now = (r_byte_index == OFS_COMMAND) ? i_data_byte : r_command;

    // Next state and results
    always_comb begin
        n_byte_index   = r_byte_index;
        n_total_length = r_total_length;
        n_header_words = r_header_words;
        n_command      = r_command;
        n_expected     = r_expected;
        n_emitted      = r_emitted;
        n_error        = r_error;
        n_family       = r_family;
        n_addr         = r_addr;
        n_mask         = r_mask;
        n_nexthop      = r_nexthop;
        n_metric       = r_metric;
        n_ent_off      = r_ent_off;
        n_ent_num      = r_ent_num;
        entry_fire     = 1'b0;
        end_status     = ST_OK;

        if (i_accept) begin
            if (r_byte_index == OFS_IHL) begin
                n_header_words = i_data_byte[3:0];
            end else if (r_byte_index == OFS_LEN_HI) begin
                n_total_length = {i_data_byte, r_total_length[7:0]};
            end else if (r_byte_index == OFS_LEN_LO) begin
                n_total_length = new_total;
                n_expected     = recip_prod[RECIP_SHIFT +: 12];
            end else if (r_byte_index == OFS_COMMAND) begin
                n_command = i_data_byte;
            end else if (r_byte_index == OFS_VERSION) begin
                if (r_error == ST_OK &&
                    !((r_command == CMD_REQUEST || r_command == CMD_RESPONSE) &&
                      i_data_byte == RIP_VERSION)) begin
                    n_error = ST_HEADER;
                end
            end else if (r_byte_index == OFS_ZERO0 || r_byte_index == OFS_ZERO1) begin
                if (r_error == ST_OK && i_data_byte != 8'd0) begin
                    n_error = ST_HEADER;
                end
            end else if (r_byte_index >= OFS_ENTRIES && r_error == ST_OK &&
                         r_ent_num < r_expected) begin
                // field capture by position in the entry; tag bytes skipped
                if (r_ent_off <= EO_FAM_LAST) begin
                    n_family = {r_family[7:0], i_data_byte};
                end else if (r_ent_off >= EO_ADDR && r_ent_off < EO_MASK) begin
                    n_addr = {i_data_byte, r_addr[31:8]};
                end else if (r_ent_off >= EO_MASK && r_ent_off < EO_NEXTHOP) begin
                    n_mask = {i_data_byte, r_mask[31:8]};
                end else if (r_ent_off >= EO_NEXTHOP && r_ent_off < EO_METRIC) begin
                    n_nexthop = {i_data_byte, r_nexthop[31:8]};
                end else if (r_ent_off >= EO_METRIC) begin
                    n_metric = {i_data_byte, r_metric[31:8]};
                end
                // entry complete: checks in priority order
                if (r_ent_off == EO_LAST) begin
                    if (r_emitted >= 5'(MAX_ENTRIES)) begin
                        n_error = ST_OVERFLOW;
                    end else if (!fam_ok) begin
                        n_error = ST_FAMILY;
                    end else if (metric_be < 32'd1 || metric_be > METRIC_MAX) begin
                        n_error = ST_METRIC;
                    end else if ((mask_inv & (mask_inv + 32'd1)) != 32'd0) begin
                        n_error = ST_MASK;
                    end else begin
                        n_emitted  = r_emitted + 5'd1;
                        entry_fire = 1'b1;
                    end
                end
            end

            // end-of-buffer status
            end_status = n_error;
            if (n_error == ST_OK) begin
                if (byte_count < 17'd32) begin
                    end_status = ST_TRUNCATED;
                end else if ({1'b0, n_total_length} > byte_count) begin
                    end_status = ST_LENGTH;
                end else if ({7'd0, n_emitted} < n_expected) begin
                    end_status = ST_TRUNCATED;
                end
            end

            // advance position, or return to reset state after the last byte
            if (i_last_byte) begin
                n_byte_index   = '0;
                n_total_length = '0;
                n_header_words = '0;
                n_command      = '0;
                n_expected     = '0;
                n_emitted      = '0;
                n_error        = ST_OK;
                n_family       = '0;
                n_addr         = '0;
                n_mask         = '0;
                n_nexthop      = '0;
                n_metric       = '0;
                n_ent_off      = '0;
                n_ent_num      = '0;
            end else if (r_byte_index != INDEX_MAX) begin
                n_byte_index = r_byte_index + 16'd1;
                if (r_byte_index >= OFS_ENTRIES) begin
                    if (r_ent_off == EO_LAST) begin
                        n_ent_off = '0;
                        n_ent_num = r_ent_num + 12'd1;
                    end else begin
                        n_ent_off = r_ent_off + 5'd1;
                    end
                end
            end
        end
    end

    // Result payloads
    always_comb begin
        o_push.entry_valid           = entry_fire;
        o_push.summary_valid         = i_accept && i_last_byte;

        o_push.entry.kind            = KIND_ENTRY;
        o_push.entry.route_addr      = r_addr;
        o_push.entry.route_mask      = r_mask;
        o_push.entry.route_nexthop   = r_nexthop;
        o_push.entry.route_metric    = {i_data_byte, r_metric[31:8]};
        o_push.entry.status          = ST_OK;
        o_push.entry.command         = r_command;
        o_push.entry.entry_count     = r_emitted + 5'd1;
        o_push.entry.run_last        = !i_last_byte;

        o_push.summary.kind          = KIND_SUMMARY;
        o_push.summary.route_addr    = '0;
        o_push.summary.route_mask    = '0;
        o_push.summary.route_nexthop = '0;
        o_push.summary.route_metric  = '0;
        o_push.summary.status        = end_status;
        o_push.summary.command       = cmd_now;
        o_push.summary.entry_count   = entry_fire ? r_emitted + 5'd1 : r_emitted;
        o_push.summary.run_last      = 1'b1;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index   <= '0;
            r_total_length <= '0;
            r_header_words <= '0;
            r_command      <= '0;
            r_expected     <= '0;
            r_emitted      <= '0;
            r_error        <= ST_OK;
            r_family       <= '0;
            r_addr         <= '0;
            r_mask         <= '0;
            r_nexthop      <= '0;
            r_metric       <= '0;
            r_ent_off      <= '0;
            r_ent_num      <= '0;
        end else begin
            r_byte_index   <= n_byte_index;
            r_total_length <= n_total_length;
            r_header_words <= n_header_words;
            r_command      <= n_command;
            r_expected     <= n_expected;
            r_emitted      <= n_emitted;
            r_error        <= n_error;
            r_family       <= n_family;
            r_addr         <= n_addr;
            r_mask         <= n_mask;
            r_nexthop      <= n_nexthop;
            r_metric       <= n_metric;
            r_ent_off      <= n_ent_off;
            r_ent_num      <= n_ent_num;
        end
    end

endmodule

>>> hdl/rpp_result_fifo.sv
// ----------------------------------------------------------------------------
// RIP packet parser result queue
// Small register queue taking up to two results per cycle, one out per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module rpp_result_fifo
    import rpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int PtrW = $clog2(FIFO_DEPTH);
    localparam int CntW = $clog2(FIFO_DEPTH + 1);

    t_result         r_mem [FIFO_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] push_num;
    logic [PtrW-1:0] summary_slot;
    logic            pop;

    // Room for a worst-case pair of results
    assign o_space  = r_count <= CntW'(FIFO_DEPTH - 2);
    assign o_valid  = r_count != '0;
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_ready;

    assign push_num     = CntW'(i_push.entry_valid) + CntW'(i_push.summary_valid);
    assign summary_slot = i_push.entry_valid ? r_wr_ptr + PtrW'(1) : r_wr_ptr;

    // Pointer and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr + PtrW'(push_num);
        n_rd_ptr = pop ? r_rd_ptr + PtrW'(1) : r_rd_ptr;
        n_count  = r_count + push_num - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, entry result ahead of summary
    always_ff @(posedge i_clk) begin
        if (i_push.entry_valid) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
        if (i_push.summary_valid) begin
            r_mem[summary_slot] <= i_push.summary;
        end
    end

endmodule

>>> hdl/rip_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// RIP packet parser
// Byte-serial IPv4/UDP/RIPv2 parser emitting route entries and a summary.
// ----------------------------------------------------------------------------
// The parser takes one packet byte per cycle, starting at the IPv4 header, and
// keeps pace with a link delivering a byte every cycle. Each byte is fully
// handled in the cycle it is accepted; it yields a route entry when an entry's
// last byte arrives and the entry passes its checks, and a packet summary on
// the byte flagged last (both when they coincide, entry first). Results go
// through a four-deep queue to the output channel, one per cycle; input ready
// drops only while fewer than two queue slots are free, so with a sink that
// keeps up the block never stalls the byte stream. No clearing pass after
// reset is needed.
module rip_packet_parser_unit
    import rpp_pkg::*;
#(
    parameter int MAX_ENTRIES = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rpp_byte_if.sink      i_byte_ch,
    rpp_result_if.source  o_result_ch
);

    t_push   push;
    t_result result;
    logic    space;
    logic    accept;

    assign i_byte_ch.ready = space;
    assign accept          = i_byte_ch.valid && space;

    // Per-byte parse
    rpp_byte_parser #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_byte_ch.data_byte),
        .i_last_byte (i_byte_ch.last_byte),
        .o_push      (push)
    );

    // Result queue
    rpp_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_valid  (o_result_ch.valid),
        .i_ready  (o_result_ch.ready),
        .o_result (result)
    );

    assign o_result_ch.kind          = result.kind;
    assign o_result_ch.route_addr    = result.route_addr;
    assign o_result_ch.route_mask    = result.route_mask;
    assign o_result_ch.route_nexthop = result.route_nexthop;
    assign o_result_ch.route_metric  = result.route_metric;
    assign o_result_ch.status        = result.status;
    assign o_result_ch.command       = result.command;
    assign o_result_ch.entry_count   = result.entry_count;
    assign o_result_ch.run_last      = result.run_last;

endmodule

>>> tb/tb_rip_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// RIP packet parser testbench
// Streams IPv4/UDP/RIPv2 packets with random content and at most one flaw each,
// plus random junk packets, through the byte channel. A local model of the parser
// predicts every route entry and packet summary, and a monitor checks results
// in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_rip_packet_parser_unit;
    import rpp_pkg::*;

    localparam int MAX_ROUTES   = 25;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 1800;
    localparam int IDLE_PCT     = 21;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 2000;

    // Packet flaws injected by the generator
    localparam int FLAW_NONE    = 0;
    localparam int FLAW_HEADER  = 1;
    localparam int FLAW_FAMILY  = 2;
    localparam int FLAW_METRIC  = 3;
    localparam int FLAW_MASK    = 4;
    localparam int FLAW_TRAILER = 5;
    localparam int FLAW_CUT     = 6;
    localparam int FLAW_LENGTH  = 7;

    typedef struct packed {
        logic [7:0] data;
        logic       eop;
        logic       hold;
    } t_stim_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rpp_byte_if   byte_ch ();
    rpp_result_if res_ch ();

    rip_packet_parser_unit #(
        .MAX_ENTRIES (MAX_ROUTES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_ch   (byte_ch),
        .o_result_ch (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_stim_byte byte_q[$];
    t_stim_byte next_byte;
    logic [7:0] pkt_bytes[$];
    t_result    expected_results[$];
    int         bytes_queued;
    int         results_predicted;
    int         results_seen;
    int         errors;
    int         cycle_cnt;
    logic       idle_in;

    wire quiet = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

    // Parser model state
    logic [15:0] pos_idx;
    logic [15:0] tot_len;
    logic [3:0]  ihl_words;
    logic [7:0]  cmd;
    logic [11:0] want_entries;
    logic [4:0]  good_entries;
    logic [2:0]  err;
    logic [15:0] fam_sr;
    logic [31:0] addr_sr;
    logic [31:0] mask_sr;
    logic [31:0] nh_sr;
    logic [31:0] met_sr;

    task automatic clear_parser();
        pos_idx      = '0;
        tot_len      = '0;
        ihl_words    = '0;
        cmd          = '0;
        want_entries = '0;
        good_entries = '0;
        err          = ST_OK;
        fam_sr       = '0;
        addr_sr      = '0;
        mask_sr      = '0;
        nh_sr        = '0;
        met_sr       = '0;
    endtask

    // Advance the model by one accepted byte and queue the results it causes
    task automatic parse_byte(input logic [7:0] b, input logic eop);
        t_result     route;
        t_result     summary;
        bit          has_route;
        int          rel;
        int          slot;
        int          ofs;
        int          hdr;
        int          count;
        logic [31:0] met_be;
        logic [31:0] inv_mask;
        logic        fam_ok;
        has_route = 1'b0;
        route     = '0;
        summary   = '0;
        if (pos_idx == OFS_IHL) begin
            ihl_words = b[3:0];
        end else if (pos_idx == OFS_LEN_HI) begin
            tot_len[15:8] = b;
        end else if (pos_idx == OFS_LEN_LO) begin
            tot_len[7:0] = b;
            hdr = 4 * ihl_words + 4;
            want_entries = (int'(tot_len) > hdr) ? 12'((int'(tot_len) - hdr) / 20) : 12'd0;
        end else if (pos_idx == OFS_COMMAND) begin
            cmd = b;
        end else if (pos_idx == OFS_VERSION) begin
            if (err == ST_OK &&
                !((cmd == CMD_REQUEST || cmd == CMD_RESPONSE) && b == RIP_VERSION))
                err = ST_HEADER;
        end else if (pos_idx == OFS_ZERO0 || pos_idx == OFS_ZERO1) begin
            if (err == ST_OK && b != 8'h00)
                err = ST_HEADER;
        end else if (pos_idx >= OFS_ENTRIES && err == ST_OK) begin
            rel  = int'(pos_idx) - int'(OFS_ENTRIES);
            slot = rel / 20;
            ofs  = rel % 20;
            if (slot < int'(want_entries)) begin
                // fields shift in little end first, family big end first
                if (ofs < 2)
                    fam_sr = {fam_sr[7:0], b};
                else if (ofs >= 4 && ofs < 8)
                    addr_sr = {b, addr_sr[31:8]};
                else if (ofs >= 8 && ofs < 12)
                    mask_sr = {b, mask_sr[31:8]};
                else if (ofs >= 12 && ofs < 16)
                    nh_sr = {b, nh_sr[31:8]};
                else if (ofs >= 16)
                    met_sr = {b, met_sr[31:8]};
                if (ofs == 19) begin
                    met_be   = {met_sr[7:0], met_sr[15:8], met_sr[23:16], met_sr[31:24]};
                    inv_mask = ~{mask_sr[7:0], mask_sr[15:8], mask_sr[23:16], mask_sr[31:24]};
                    fam_ok   = (cmd == CMD_RESPONSE && fam_sr == FAMILY_INET) ||
                               (cmd == CMD_REQUEST && fam_sr == FAMILY_NONE);
                    // overflow, family, metric, mask in that order
                    if (good_entries >= MAX_ROUTES) begin
                        err = ST_OVERFLOW;
                    end else if (!fam_ok) begin
                        err = ST_FAMILY;
                    end else if (met_be < 32'd1 || met_be > METRIC_MAX) begin
                        err = ST_METRIC;
                    end else if ((inv_mask & (inv_mask + 32'd1)) != 32'd0) begin
                        err = ST_MASK;
                    end else begin
                        good_entries        = good_entries + 5'd1;
                        has_route           = 1'b1;
                        route.kind          = KIND_ENTRY;
                        route.route_addr    = addr_sr;
                        route.route_mask    = mask_sr;
                        route.route_nexthop = nh_sr;
                        route.route_metric  = met_sr;
                        route.status        = ST_OK;
                        route.command       = cmd;
                        route.entry_count   = good_entries;
                    end
                end
            end
        end

        if (eop) begin
            count               = int'(pos_idx) + 1;
            summary.kind        = KIND_SUMMARY;
            summary.status      = err;
            summary.command     = cmd;
            summary.entry_count = good_entries;
            summary.run_last    = 1'b1;
            if (err == ST_OK) begin
                if (count < 32)
                    summary.status = ST_TRUNCATED;
                else if (int'(tot_len) > count)
                    summary.status = ST_LENGTH;
                else if (good_entries < want_entries)
                    summary.status = ST_TRUNCATED;
            end
            clear_parser();
        end else if (pos_idx != INDEX_MAX) begin
            pos_idx = pos_idx + 16'd1;
        end

        if (has_route) begin
            route.run_last = !eop;
            expected_results.push_back(route);
            results_predicted++;
        end
        if (eop) begin
            expected_results.push_back(summary);
            results_predicted++;
        end
    endtask

    // Move the packet under construction to the stimulus queue
    task automatic commit_packet(input bit hold);
        t_stim_byte sb;
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            sb.data = pkt_bytes[i];
            sb.eop  = (i == pkt_bytes.size() - 1);
            sb.hold = hold && (i == 0);
            byte_q.push_back(sb);
        end
        bytes_queued += pkt_bytes.size();
        pkt_bytes.delete();
    endtask

    task automatic push_be32(input logic [31:0] v);
        pkt_bytes.push_back(v[31:24]);
        pkt_bytes.push_back(v[23:16]);
        pkt_bytes.push_back(v[15:8]);
        pkt_bytes.push_back(v[7:0]);
    endtask

    // Build an IPv4/UDP/RIPv2 packet with random content and at most one flaw
    task automatic build_rip_packet(input int n_ent, input int flaw);
        int          ihl;
        int          body_len;
        int          slack;
        int          bad_ent;
        int          plen;
        int          cut;
        logic [15:0] tot16;
        logic [7:0]  rip_cmd;
        logic [7:0]  ver;
        logic [7:0]  z0;
        logic [7:0]  z1;
        logic [15:0] fam;
        logic [31:0] mask;
        logic [31:0] metric;
        pkt_bytes.delete();
        ihl     = ($urandom_range(99) < 85) ? 5 : $urandom_range(15);
        rip_cmd = ($urandom_range(3) == 0) ? CMD_REQUEST : CMD_RESPONSE;
        ver     = RIP_VERSION;
        z0      = 8'h00;
        z1      = 8'h00;
        if (flaw == FLAW_HEADER) begin
            case ($urandom_range(3))
                0: begin
                    rip_cmd = $urandom_range(1) ? 8'h00 : 8'($urandom_range(3, 255));
                end
                1: begin
                    ver = 8'($urandom);
                    if (ver == RIP_VERSION)
                        ver = 8'h01;
                end
                2: z0 = 8'($urandom_range(1, 255));
                default: z1 = 8'($urandom_range(1, 255));
            endcase
        end
        body_len = 32 + 20 * n_ent;
        slack    = ($urandom_range(3) == 0) ? $urandom_range(1, 19) : 0;
        tot16    = 16'(body_len + slack);
        if (flaw == FLAW_LENGTH)
            tot16 = tot16 + 16'($urandom_range(1, 60));
        if ($urandom_range(49) == 0)
            tot16 = $urandom_range(1) ? 16'hFFFF : 16'($urandom);
        bad_ent = (n_ent > 0) ? $urandom_range(n_ent - 1) : 0;

        // IPv4 and UDP headers, then the RIP header at offset 28
        pkt_bytes.push_back({($urandom_range(3) == 0) ? 4'($urandom) : 4'h4, 4'(ihl)});
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(tot16[15:8]);
        pkt_bytes.push_back(tot16[7:0]);
        for (int i = 4; i < 28; i++)
            pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(rip_cmd);
        pkt_bytes.push_back(ver);
        pkt_bytes.push_back(z0);
        pkt_bytes.push_back(z1);

        for (int k = 0; k < n_ent; k++) begin
            fam = (rip_cmd == CMD_REQUEST) ? FAMILY_NONE : FAMILY_INET;
            if (flaw == FLAW_FAMILY && k == bad_ent)
                fam = fam ^ 16'($urandom_range(1, 65535));
            plen = $urandom_range(32);
            mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
            // low bit set with high bit clear can never be a prefix
            if (flaw == FLAW_MASK && k == bad_ent)
                mask = (32'($urandom) | 32'h1) & 32'h7FFF_FFFF;
            metric = 32'($urandom_range(1, 16));
            if (flaw == FLAW_METRIC && k == bad_ent) begin
                case ($urandom_range(2))
                    0: metric = 32'd0;
                    1: metric = 32'd17;
                    default: metric = 32'($urandom) | 32'h0001_0000;
                endcase
            end
            pkt_bytes.push_back(fam[15:8]);
            pkt_bytes.push_back(fam[7:0]);
            pkt_bytes.push_back(8'($urandom));
            pkt_bytes.push_back(8'($urandom));
            push_be32(32'($urandom));
            push_be32(mask);
            push_be32(32'($urandom));
            push_be32(metric);
        end

        for (int i = 0; i < slack; i++)
            pkt_bytes.push_back(8'($urandom));
        if (flaw == FLAW_TRAILER) begin
            for (int i = $urandom_range(1, 8); i > 0; i--)
                pkt_bytes.push_back(8'($urandom));
        end
        if (flaw == FLAW_CUT) begin
            cut = $urandom_range(1, pkt_bytes.size() - 1);
            while (pkt_bytes.size() > cut)
                void'(pkt_bytes.pop_back());
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, seen);
        end
    endtask

    // Byte driver: holds an item until accepted, idles at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            clear_parser();
        end else begin
            if (byte_ch.valid && byte_ch.ready)
                parse_byte(byte_ch.data_byte, byte_ch.last_byte);
            idle_in = !quiet && ($urandom_range(99) < IDLE_PCT);
            if (!byte_ch.valid || byte_ch.ready) begin
                if (byte_q.size() != 0 && !idle_in &&
                    !(byte_q[0].hold && results_predicted != results_seen)) begin
                    next_byte = byte_q.pop_front();
                    byte_ch.valid     <= 1'b1;
                    byte_ch.data_byte <= next_byte.data;
                    byte_ch.last_byte <= next_byte.eop;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result mismatch: expected none, actual kind %0d status %0d",
                             $time, res_ch.kind, res_ch.status);
                end else begin
                    t_result want;
                    want = expected_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(res_ch.kind));
                    check_field("route_addr", want.route_addr, res_ch.route_addr);
                    check_field("route_mask", want.route_mask, res_ch.route_mask);
                    check_field("route_nexthop", want.route_nexthop, res_ch.route_nexthop);
                    check_field("route_metric", want.route_metric, res_ch.route_metric);
                    check_field("status", 32'(want.status), 32'(res_ch.status));
                    check_field("command", 32'(want.command), 32'(res_ch.command));
                    check_field("entry_count", 32'(want.entry_count), 32'(res_ch.entry_count));
                    check_field("run_last", 32'(want.run_last), 32'(res_ch.run_last));
                end
                results_seen <= results_seen + 1;
            end
            res_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[rip_packet_parser_unit] ERROR");
            $finish;
        end
    end

    initial begin
        int r;
        int n;
        int flaw;
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last_byte = 1'b0;
        res_ch.ready      = 1'b0;
        bytes_queued      = 0;
        results_predicted = 0;
        results_seen      = 0;
        errors            = 0;
        cycle_cnt         = 0;

        // Directed: one-byte packets at the byte extremes, a short runt
        pkt_bytes.push_back(8'h00);
        commit_packet(1'b0);
        pkt_bytes.push_back(8'hFF);
        commit_packet(1'b0);
        for (int i = 0; i < 16; i++)
            pkt_bytes.push_back((i % 2) ? 8'hFF : 8'h00);
        commit_packet(1'b0);

        // Each flaw once, then a packet past the entry limit
        for (int f = FLAW_NONE; f <= FLAW_LENGTH; f++) begin
            build_rip_packet($urandom_range(1, 3), f);
            commit_packet(1'b0);
        end
        build_rip_packet(MAX_ROUTES + 1, FLAW_NONE);
        commit_packet(1'b1);

        // Random packets up to the byte budget: random junk, well formed and flawed ones
        while (bytes_queued < RANDOM_BYTES) begin
            r = $urandom_range(99);
            if (r < 12) begin
                for (int i = $urandom_range(1, 48); i > 0; i--)
                    pkt_bytes.push_back(8'($urandom));
            end else begin
                n = ($urandom_range(29) == 0) ? $urandom_range(20, MAX_ROUTES + 2)
                                              : $urandom_range(0, 4);
                flaw = (r < 60) ? FLAW_NONE : $urandom_range(FLAW_HEADER, FLAW_LENGTH);
                build_rip_packet(n, flaw);
            end
            commit_packet($urandom_range(39) == 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || byte_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("[rip_packet_parser_unit] OK");
        else
            $display("[rip_packet_parser_unit] ERROR");
        $finish;
    end

endmodule

>>> rip_packet_parser_unit.f
hdl/rpp_pkg.sv
hdl/rpp_if.sv
hdl/rpp_byte_parser.sv
hdl/rpp_result_fifo.sv
hdl/rip_packet_parser_unit.sv
tb/tb_rip_packet_parser_unit.sv
